FILE: hw/rtl/wbc_pkg.sv
// Shared types, widths and codes for the white blob centroid steering block.
// Used by the channel interfaces and every RTL module; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wbc_pkg;

    localparam int POS_W      = 12;   // column, row, centroid and bound width
    localparam int LVL_W      = 8;
    localparam int BAND_W     = 11;
    localparam int CNT_W      = 25;
    localparam int SUM_W      = 36;
    localparam int PROD_W     = POS_W + CNT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int CMD_W      = 3;
    localparam int STEP_W     = 5;

    localparam logic [CNT_W-1:0] TALLY_MAX = CNT_W'(16777216);

    localparam logic [POS_W-1:0]  RST_IMAGE_WIDTH = POS_W'(640);
    localparam logic [LVL_W-1:0]  RST_WHITE_LEVEL = LVL_W'(255);
    localparam logic [BAND_W-1:0] RST_HALF_BAND   = BAND_W'(25);
    localparam logic [CNT_W-1:0]  RST_MIN_WHITE   = CNT_W'(50);
    localparam logic [CNT_W-1:0]  RST_CATCH_LOW   = CNT_W'(11300);
    localparam logic [CNT_W-1:0]  RST_CATCH_HIGH  = CNT_W'(18800);
    localparam logic [POS_W-1:0]  RST_NEAR_ROW    = POS_W'(580);

    // Sequencer steps: five bound compares, then one quotient bit per step
    localparam logic [STEP_W-1:0] STEP_LB   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LW   = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_RB   = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_RW   = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_NEAR = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_CDIV = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_RDIV = STEP_W'(5 + POS_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(5 + 2 * POS_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_WHITE_LEVEL      = 3'd1,
        REG_CENTER_HALF_BAND = 3'd2,
        REG_MIN_WHITE_COUNT  = 3'd3,
        REG_CATCH_COUNT_LOW  = 3'd4,
        REG_CATCH_COUNT_HIGH = 3'd5,
        REG_NEAR_ROW_LIMIT   = 3'd6
    } t_reg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_STOP    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_LEFT    = 3'd2,
        CMD_RIGHT   = 3'd3,
        CMD_REVERSE = 3'd4,
        CMD_CATCH   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_STOP     = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_TURN     = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_LOAD = 3'd1,
        S_MUL  = 3'd2,
        S_CMP  = 3'd3,
        S_FIN  = 3'd4
    } t_seq_state;

    typedef struct packed {
        logic [CNT_W-1:0] tally;
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
    } t_frame_stats;

    typedef struct packed {
        logic [POS_W-1:0]  image_width;
        logic [BAND_W-1:0] center_half_band;
        logic [CNT_W-1:0]  min_white_count;
        logic [CNT_W-1:0]  catch_count_low;
        logic [CNT_W-1:0]  catch_count_high;
        logic [POS_W-1:0]  near_row_limit;
    } t_steer_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/wbc_pix_if.sv
// Pixel input channel: valid/ready handshake with one RGB pixel and end of frame flag.
// Depends on wbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wbc_pix_if;
    logic                      valid;
    logic                      ready;
    logic [wbc_pkg::LVL_W-1:0] red;
    logic [wbc_pkg::LVL_W-1:0] green;
    logic [wbc_pkg::LVL_W-1:0] blue;
    logic                      last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wbc_res_if.sv
// Result channel: valid/ready handshake with drive command, white count and centroid.
// Depends on wbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wbc_res_if;
    logic                      valid;
    logic                      ready;
    logic [wbc_pkg::CMD_W-1:0] command;
    logic [wbc_pkg::CNT_W-1:0] white_count;
    logic [wbc_pkg::POS_W-1:0] center_col;
    logic [wbc_pkg::POS_W-1:0] center_row;

    modport source (output valid, command, white_count, center_col, center_row, input ready);
    modport sink   (input valid, command, white_count, center_col, center_row, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wbc_accum.sv
// Per-pixel accumulation: raster position, white tally and column/row sums.
// Snapshots the frame totals on the last pixel. Depends on wbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbc_accum (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_take,
    input  wire [wbc_pkg::LVL_W-1:0]     i_red,
    input  wire [wbc_pkg::LVL_W-1:0]     i_green,
    input  wire [wbc_pkg::LVL_W-1:0]     i_blue,
    input  wire                          i_last,
    input  wire [wbc_pkg::POS_W-1:0]     i_image_width,
    input  wire [wbc_pkg::LVL_W-1:0]     i_white_level,
    output wbc_pkg::t_frame_stats        o_stats
);

    logic [wbc_pkg::POS_W-1:0] r_col;
    logic [wbc_pkg::POS_W-1:0] r_row;
    logic [wbc_pkg::CNT_W-1:0] r_tally;
    logic [wbc_pkg::SUM_W-1:0] r_col_sum;
    logic [wbc_pkg::SUM_W-1:0] r_row_sum;
    wbc_pkg::t_frame_stats     r_snap;

    logic [wbc_pkg::POS_W-1:0] n_col;
    logic [wbc_pkg::POS_W-1:0] n_row;
    logic [wbc_pkg::CNT_W-1:0] n_tally;
    logic [wbc_pkg::SUM_W-1:0] n_col_sum;
    logic [wbc_pkg::SUM_W-1:0] n_row_sum;

    logic                      is_white;
    logic [wbc_pkg::POS_W:0]   eff_w;
    logic [wbc_pkg::POS_W:0]   col_inc;
    logic                      wrap;

    // a zero width behaves as one pixel per row
    assign eff_w    = (i_image_width == '0) ? (wbc_pkg::POS_W+1)'(1) : {1'b0, i_image_width};
    assign col_inc  = {1'b0, r_col} + (wbc_pkg::POS_W+1)'(1);
    assign wrap     = (col_inc >= eff_w);
    assign is_white = (i_red == i_white_level) && (i_green == i_white_level)
                      && (i_blue == i_white_level) && (r_tally < wbc_pkg::TALLY_MAX);

    always_comb begin
        n_tally   = r_tally;
        n_col_sum = r_col_sum;
        n_row_sum = r_row_sum;
        if (is_white) begin
            n_tally   = r_tally + wbc_pkg::CNT_W'(1);
            n_col_sum = r_col_sum + wbc_pkg::SUM_W'(r_col);
            n_row_sum = r_row_sum + wbc_pkg::SUM_W'(r_row);
        end
        n_col = wrap ? '0 : col_inc[wbc_pkg::POS_W-1:0];
        n_row = wrap ? r_row + wbc_pkg::POS_W'(1) : r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_tally   <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_col     <= '0;
                r_row     <= '0;
                r_tally   <= '0;
                r_col_sum <= '0;
                r_row_sum <= '0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_tally   <= n_tally;
                r_col_sum <= n_col_sum;
                r_row_sum <= n_row_sum;
            end
        end
    end

    // frame totals include the last pixel itself
    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_snap.tally   <= n_tally;
            r_snap.col_sum <= n_col_sum;
            r_snap.row_sum <= n_row_sum;
        end
    end

    assign o_stats = r_snap;

`ifndef SYNTHESIS
    a_tally_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= wbc_pkg::TALLY_MAX)
        else $error("white tally above its cap");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last |=> r_tally == '0 && r_col == '0 && r_row == '0
                             && r_col_sum == '0 && r_row_sum == '0)
        else $error("accumulators not cleared after end of frame");

    a_sums_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally == '0 |-> r_col_sum == '0 && r_row_sum == '0)
        else $error("sums non-zero with no white pixels counted");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/wbc_steer_seq.sv
// End-of-frame sequencer: one shared 12x25 multiplier drives the bound compares
// and both centroid divisions (one quotient bit per step). Depends on wbc_pkg, wbc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module wbc_steer_seq (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wbc_pkg::t_frame_stats     i_stats,
    input  wbc_pkg::t_steer_cfg       i_cfg,
    output logic                      o_busy,
    wbc_res_if.source                 o_res
);

    wbc_pkg::t_seq_state        r_state, n_state;
    logic [wbc_pkg::STEP_W-1:0] r_step;
    logic [wbc_pkg::PROD_W-1:0] r_prod;
    logic [wbc_pkg::POS_W-1:0]  r_qcol;
    logic [wbc_pkg::POS_W-1:0]  r_qrow;
    logic                       r_le_lb, r_le_lw, r_ge_rb, r_ge_rw, r_gt_near;
    logic                       r_stop;
    wbc_pkg::t_mode             r_mode;

    logic                       r_out_valid;
    wbc_pkg::t_cmd              r_out_cmd;
    logic [wbc_pkg::CNT_W-1:0]  r_out_count;
    logic [wbc_pkg::POS_W-1:0]  r_out_col;
    logic [wbc_pkg::POS_W-1:0]  r_out_row;

    logic [wbc_pkg::CNT_W-1:0]  n_cnt;
    logic                       too_few;
    logic                       can_load;
    logic                       do_load;

    logic [wbc_pkg::BAND_W-1:0] half;
    logic [wbc_pkg::BAND_W-1:0] lb;
    logic [wbc_pkg::POS_W-1:0]  rb;
    logic [wbc_pkg::POS_W-1:0]  lw;
    logic [wbc_pkg::POS_W+1:0]  w3;
    logic [wbc_pkg::POS_W-1:0]  rw;

    logic                       in_cdiv, in_rdiv;
    logic [wbc_pkg::STEP_W-1:0] div_idx;
    logic [3:0]                 bitpos;
    logic [wbc_pkg::POS_W-1:0]  trial_col, trial_row;
    logic [wbc_pkg::POS_W-1:0]  operand;
    logic [wbc_pkg::PROD_W-1:0] mul_res;
    logic [wbc_pkg::PROD_W-1:0] csum_x, rsum_x;

    wbc_pkg::t_cmd              dec_cmd;
    wbc_pkg::t_mode             dec_mode;

    assign n_cnt   = i_stats.tally;
    assign too_few = (n_cnt <= i_cfg.min_white_count) || (n_cnt == '0);
    assign csum_x  = {1'b0, i_stats.col_sum};
    assign rsum_x  = {1'b0, i_stats.row_sum};

    // centre band and quarter bounds from the raw width
    assign half = i_cfg.image_width[wbc_pkg::POS_W-1:1];
    assign lb   = (half > i_cfg.center_half_band) ? half - i_cfg.center_half_band : '0;
    assign rb   = {1'b0, half} + {1'b0, i_cfg.center_half_band};
    assign lw   = {2'b00, i_cfg.image_width[wbc_pkg::POS_W-1:2]};
    assign w3   = {2'b00, i_cfg.image_width} + {1'b0, i_cfg.image_width, 1'b0};
    assign rw   = w3[wbc_pkg::POS_W+1:2];

    assign in_cdiv = (r_step >= wbc_pkg::STEP_CDIV) && (r_step < wbc_pkg::STEP_RDIV);
    assign in_rdiv = (r_step >= wbc_pkg::STEP_RDIV);
    assign div_idx = in_rdiv ? r_step - wbc_pkg::STEP_RDIV : r_step - wbc_pkg::STEP_CDIV;
    // quotient bits are tried most significant first
    assign bitpos    = 4'(wbc_pkg::POS_W - 1) - div_idx[3:0];
    assign trial_col = r_qcol | (wbc_pkg::POS_W'(1) << bitpos);
    assign trial_row = r_qrow | (wbc_pkg::POS_W'(1) << bitpos);

    always_comb begin
        operand = '0;
        if (in_rdiv) begin
            operand = trial_row;
        end else if (in_cdiv) begin
            operand = trial_col;
        end else begin
            unique case (r_step)
                wbc_pkg::STEP_LB:   operand = {1'b0, lb};
                wbc_pkg::STEP_LW:   operand = lw;
                wbc_pkg::STEP_RB:   operand = rb;
                wbc_pkg::STEP_RW:   operand = rw;
                wbc_pkg::STEP_NEAR: operand = i_cfg.near_row_limit;
                default:            operand = '0;
            endcase
        end
    end

    assign mul_res = operand * n_cnt;

    // drive decision from the registered compare flags, the white count and the previous mode
    always_comb begin
        dec_cmd  = wbc_pkg::CMD_FORWARD;
        dec_mode = wbc_pkg::MODE_STRAIGHT;
        if (r_stop) begin
            dec_cmd  = wbc_pkg::CMD_STOP;
            dec_mode = wbc_pkg::MODE_STOP;
        end else if (r_le_lb) begin
            if (r_le_lw || r_mode == wbc_pkg::MODE_TURN) begin
                dec_cmd  = wbc_pkg::CMD_LEFT;
                dec_mode = wbc_pkg::MODE_TURN;
            end
        end else if (r_ge_rb) begin
            if (r_ge_rw || r_mode == wbc_pkg::MODE_TURN) begin
                dec_cmd  = wbc_pkg::CMD_RIGHT;
                dec_mode = wbc_pkg::MODE_TURN;
            end
        end else if (n_cnt >= i_cfg.catch_count_low && n_cnt <= i_cfg.catch_count_high) begin
            dec_cmd = wbc_pkg::CMD_CATCH;
        end else if (n_cnt > i_cfg.catch_count_high || r_gt_near) begin
            dec_cmd = wbc_pkg::CMD_REVERSE;
        end
    end

    assign can_load = !r_out_valid || o_res.ready;

    always_comb begin
        n_state = r_state;
        do_load = 1'b0;
        unique case (r_state)
            wbc_pkg::S_IDLE: if (i_start) n_state = wbc_pkg::S_LOAD;
            wbc_pkg::S_LOAD: n_state = too_few ? wbc_pkg::S_FIN : wbc_pkg::S_MUL;
            wbc_pkg::S_MUL:  n_state = wbc_pkg::S_CMP;
            wbc_pkg::S_CMP: begin
                if (r_step == wbc_pkg::STEP_LAST) n_state = wbc_pkg::S_FIN;
                else                              n_state = wbc_pkg::S_MUL;
            end
            wbc_pkg::S_FIN: begin
                if (can_load) begin
                    do_load = 1'b1;
                    n_state = wbc_pkg::S_IDLE;
                end
            end
            default: n_state = wbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wbc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == wbc_pkg::S_LOAD) begin
            r_step <= '0;
        end else if (r_state == wbc_pkg::S_CMP) begin
            r_step <= r_step + wbc_pkg::STEP_W'(1);
        end
    end

    // datapath of the shared unit
    always_ff @(posedge i_clk) begin
        if (r_state == wbc_pkg::S_LOAD) begin
            r_stop <= too_few;
            r_qcol <= '0;
            r_qrow <= '0;
        end
        if (r_state == wbc_pkg::S_MUL) begin
            r_prod <= mul_res;
        end
        if (r_state == wbc_pkg::S_CMP) begin
            if (in_rdiv) begin
                if (r_prod <= rsum_x) r_qrow <= trial_row;
            end else if (in_cdiv) begin
                if (r_prod <= csum_x) r_qcol <= trial_col;
            end else begin
                case (r_step)
                    wbc_pkg::STEP_LB:   r_le_lb   <= (csum_x <= r_prod);
                    wbc_pkg::STEP_LW:   r_le_lw   <= (csum_x <= r_prod);
                    wbc_pkg::STEP_RB:   r_ge_rb   <= (csum_x >= r_prod);
                    wbc_pkg::STEP_RW:   r_ge_rw   <= (csum_x >= r_prod);
                    wbc_pkg::STEP_NEAR: r_gt_near <= (rsum_x > r_prod);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wbc_pkg::MODE_STOP;
            r_out_valid <= 1'b0;
        end else begin
            if (do_load) begin
                r_mode      <= dec_mode;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_out_cmd   <= dec_cmd;
            r_out_count <= n_cnt;
            r_out_col   <= r_qcol;
            r_out_row   <= r_qrow;
        end
    end

    assign o_busy            = (r_state != wbc_pkg::S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.command     = r_out_cmd;
    assign o_res.white_count = r_out_count;
    assign o_res.center_col  = r_out_col;
    assign o_res.center_row  = r_out_row;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == wbc_pkg::S_IDLE)
        else $error("frame end taken while sequencer busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wbc_pkg::S_MUL || r_state == wbc_pkg::S_CMP)
        |-> r_step <= wbc_pkg::STEP_LAST)
        else $error("sequencer step out of range");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_cmd == wbc_pkg::CMD_STOP |-> r_out_col == '0 && r_out_row == '0)
        else $error("stop result carries a centroid");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wbc_pkg::S_FIN && r_out_valid && !o_res.ready |=> r_state == wbc_pkg::S_FIN)
        else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/white_blob_centroid_steering.sv
// Channel   Dir  Handshake      Payload
// i_pix     in   valid/ready    red, green, blue, last_pixel
// o_res     out  valid/ready    command, white_count, center_col, center_row
// i_cfg_*   in   write enable   register index, data
// Ordinary pixels are taken one per cycle. After the pixel flagged last the input stalls
// while the shared multiplier runs five bound compares and two 12-bit quotients (29 steps,
// each a multiply state and a compare state, plus load and finish); only load and finish when
// too few pixels are white; longer if the result register is full.
// Reset is synchronous, active low; it restores register defaults and clears the frame state.
// Depends on wbc_pkg, wbc_pix_if, wbc_res_if, wbc_accum, wbc_steer_seq.
`timescale 1ns / 1ps
`default_nettype none

module white_blob_centroid_steering (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    wbc_pix_if.sink                           i_pix,
    wbc_res_if.source                         o_res,
    input  wire                               i_cfg_we,
    input  wire [wbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [wbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [wbc_pkg::POS_W-1:0]  r_image_width;
    logic [wbc_pkg::LVL_W-1:0]  r_white_level;
    logic [wbc_pkg::BAND_W-1:0] r_half_band;
    logic [wbc_pkg::CNT_W-1:0]  r_min_white;
    logic [wbc_pkg::CNT_W-1:0]  r_catch_low;
    logic [wbc_pkg::CNT_W-1:0]  r_catch_high;
    logic [wbc_pkg::POS_W-1:0]  r_near_row;

    wbc_pkg::t_steer_cfg        steer_cfg;
    wbc_pkg::t_frame_stats      stats;
    logic                       seq_busy;
    logic                       pix_take;
    logic                       frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= wbc_pkg::RST_IMAGE_WIDTH;
            r_white_level <= wbc_pkg::RST_WHITE_LEVEL;
            r_half_band   <= wbc_pkg::RST_HALF_BAND;
            r_min_white   <= wbc_pkg::RST_MIN_WHITE;
            r_catch_low   <= wbc_pkg::RST_CATCH_LOW;
            r_catch_high  <= wbc_pkg::RST_CATCH_HIGH;
            r_near_row    <= wbc_pkg::RST_NEAR_ROW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wbc_pkg::REG_IMAGE_WIDTH:      r_image_width <= i_cfg_data[wbc_pkg::POS_W-1:0];
                wbc_pkg::REG_WHITE_LEVEL:      r_white_level <= i_cfg_data[wbc_pkg::LVL_W-1:0];
                wbc_pkg::REG_CENTER_HALF_BAND: r_half_band   <= i_cfg_data[wbc_pkg::BAND_W-1:0];
                wbc_pkg::REG_MIN_WHITE_COUNT:  r_min_white   <= i_cfg_data[wbc_pkg::CNT_W-1:0];
                wbc_pkg::REG_CATCH_COUNT_LOW:  r_catch_low   <= i_cfg_data[wbc_pkg::CNT_W-1:0];
                wbc_pkg::REG_CATCH_COUNT_HIGH: r_catch_high  <= i_cfg_data[wbc_pkg::CNT_W-1:0];
                wbc_pkg::REG_NEAR_ROW_LIMIT:   r_near_row    <= i_cfg_data[wbc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign steer_cfg.image_width      = r_image_width;
    assign steer_cfg.center_half_band = r_half_band;
    assign steer_cfg.min_white_count  = r_min_white;
    assign steer_cfg.catch_count_low  = r_catch_low;
    assign steer_cfg.catch_count_high = r_catch_high;
    assign steer_cfg.near_row_limit   = r_near_row;

    assign i_pix.ready = !seq_busy;
    assign pix_take    = i_pix.valid && !seq_busy;
    assign frame_end   = pix_take && i_pix.last_pixel;

    wbc_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (pix_take),
        .i_red         (i_pix.red),
        .i_green       (i_pix.green),
        .i_blue        (i_pix.blue),
        .i_last        (i_pix.last_pixel),
        .i_image_width (r_image_width),
        .i_white_level (r_white_level),
        .o_stats       (stats)
    );

    wbc_steer_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (frame_end),
        .i_stats (stats),
        .i_cfg   (steer_cfg),
        .o_busy  (seq_busy),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
